[src/pbv_pkg.sv]
// Shared types, constants and helper functions for the pose-to-body-velocity block.
// No dependencies.
package pbv_pkg;

  localparam int unsigned PosFracBitsDef = 16;
  localparam int unsigned AngFracBitsDef = 13;
  localparam int unsigned TrigStepsDef   = 16;
  localparam int unsigned AtanEntries    = 24;
  localparam int unsigned DivW           = 64;

  localparam logic [63:0] NsPerSec  = 64'd1000000000;
  localparam logic signed [33:0] GainQ30  = 34'sd652032874;
  localparam logic signed [39:0] PiQ30    = 40'sd3373259426;
  localparam logic signed [39:0] HalfPiQ30 = 40'sd1686629713;

  typedef struct packed {
    logic load;
    logic dt_mul;
    logic dt_add;
    logic ang_start;
    logic ang_take;
    logic lin_start;
    logic scl_start;
    logic lin_take;
    logic out_load;
  } pbv_cmd_t;

  typedef struct packed {
    logic dt_zero;
    logic div_busy;
    logic trig_busy;
  } pbv_stat_t;

  function automatic logic signed [39:0] atan_q30(input logic [4:0] i);
    logic signed [39:0] r;
    unique case (i)
      5'd0:  r = 40'sd843314857;
      5'd1:  r = 40'sd497837829;
      5'd2:  r = 40'sd263043837;
      5'd3:  r = 40'sd133525159;
      5'd4:  r = 40'sd67021687;
      5'd5:  r = 40'sd33543516;
      5'd6:  r = 40'sd16775851;
      5'd7:  r = 40'sd8388437;
      5'd8:  r = 40'sd4194283;
      5'd9:  r = 40'sd2097149;
      5'd10: r = 40'sd1048575;
      5'd11: r = 40'sd524288;
      5'd12: r = 40'sd262144;
      5'd13: r = 40'sd131072;
      5'd14: r = 40'sd65536;
      5'd15: r = 40'sd32768;
      5'd16: r = 40'sd16384;
      5'd17: r = 40'sd8192;
      5'd18: r = 40'sd4096;
      5'd19: r = 40'sd2048;
      5'd20: r = 40'sd1024;
      5'd21: r = 40'sd512;
      5'd22: r = 40'sd256;
      5'd23: r = 40'sd128;
      default: r = 40'sd0;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] sat32(input logic neg, input logic [63:0] m);
    logic [31:0] r;
    if (neg) begin
      r = (m > 64'h8000_0000) ? 32'h8000_0000 : (32'd0 - m[31:0]);
    end else begin
      r = (m > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : m[31:0];
    end
    return r;
  endfunction

endpackage

[src/pbv_if.sv]
// Valid/ready channel interfaces for pose words and velocity words.
// No dependencies.
interface pbv_pose_if;
  logic        valid;
  logic        ready;
  logic [31:0] pos_x;
  logic [31:0] pos_y;
  logic [15:0] heading;
  logic [30:0] stamp_sec;
  logic [29:0] stamp_nsec;
  modport source (output valid, pos_x, pos_y, heading, stamp_sec, stamp_nsec, input ready);
  modport sink (input valid, pos_x, pos_y, heading, stamp_sec, stamp_nsec, output ready);
endinterface

interface pbv_vel_if;
  logic        valid;
  logic        ready;
  logic [31:0] linear_speed;
  logic [31:0] angular_speed;
  logic        zero_step;
  modport source (output valid, linear_speed, angular_speed, zero_step, input ready);
  modport sink (input valid, linear_speed, angular_speed, zero_step, output ready);
endinterface

[src/pbv_div.sv]
// Radix-2 restoring unsigned divider, one quotient bit per cycle.
// Depends on pbv_pkg.
module pbv_div
  import pbv_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [DivW-1:0] num_i,
  input  logic [DivW-1:0] den_i,
  output logic            busy_o,
  output logic [DivW-1:0] quo_o
);
  localparam int unsigned CntW = $clog2(DivW + 1);

  logic [CntW-1:0] cnt_q, cnt_d;
  logic [DivW-1:0] quo_q, quo_d, den_q, den_d, rem_q, rem_d;
  logic [DivW:0]   rem_sh;

  assign rem_sh = {rem_q, quo_q[DivW-1]};

  always_comb begin
    cnt_d = cnt_q;
    quo_d = quo_q;
    den_d = den_q;
    rem_d = rem_q;
    if (start_i) begin
      cnt_d = CntW'(DivW);
      quo_d = num_i;
      den_d = den_i;
      rem_d = '0;
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - 1'b1;
      if (rem_sh >= {1'b0, den_q}) begin
        rem_d = DivW'(rem_sh - {1'b0, den_q});
        quo_d = {quo_q[DivW-2:0], 1'b1};
      end else begin
        rem_d = rem_sh[DivW-1:0];
        quo_d = {quo_q[DivW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    den_q <= den_d;
    rem_q <= rem_d;
  end

  assign busy_o = (cnt_q != '0);
  assign quo_o  = quo_q;
endmodule

[src/pbv_ctrl.sv]
// Sequencer for the velocity estimator: issues datapath commands, owns the handshakes.
// Depends on pbv_pkg.
module pbv_ctrl
  import pbv_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  input  pbv_stat_t stat_i,
  output pbv_cmd_t  cmd_o
);
  localparam logic [3:0] StIdle  = 4'd0;
  localparam logic [3:0] StDtMul = 4'd1;
  localparam logic [3:0] StDtAdd = 4'd2;
  localparam logic [3:0] StChk   = 4'd3;
  localparam logic [3:0] StAngW  = 4'd4;
  localparam logic [3:0] StLinM  = 4'd5;
  localparam logic [3:0] StLinW  = 4'd6;
  localparam logic [3:0] StSclW  = 4'd7;
  localparam logic [3:0] StFin   = 4'd8;

  logic [3:0] state_q, state_d;
  logic       oval_q, oval_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StDtMul;
        end
      end
      StDtMul: begin
        cmd_o.dt_mul = 1'b1;
        state_d      = StDtAdd;
      end
      StDtAdd: begin
        cmd_o.dt_add = 1'b1;
        state_d      = StChk;
      end
      StChk: begin
        if (stat_i.dt_zero) begin
          state_d = StFin;
        end else begin
          cmd_o.ang_start = 1'b1;
          state_d         = StAngW;
        end
      end
      StAngW: begin
        if (!stat_i.div_busy && !stat_i.trig_busy) begin
          cmd_o.ang_take = 1'b1;
          state_d        = StLinM;
        end
      end
      StLinM: begin
        cmd_o.lin_start = 1'b1;
        state_d         = StLinW;
      end
      StLinW: begin
        if (!stat_i.div_busy) begin
          cmd_o.scl_start = 1'b1;
          state_d         = StSclW;
        end
      end
      StSclW: begin
        if (!stat_i.div_busy) begin
          cmd_o.lin_take = 1'b1;
          state_d        = StFin;
        end
      end
      StFin: begin
        if (!oval_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    oval_d = oval_q;
    if (cmd_o.out_load) begin
      oval_d = 1'b1;
    end else if (out_ready_i) begin
      oval_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      oval_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      oval_q  <= oval_d;
    end
  end

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = oval_q;
endmodule

[src/pbv_dp.sv]
// Datapath: pose history, time step, shared divider, iterative CORDIC, output word.
// Depends on pbv_pkg and pbv_div.
module pbv_dp
  import pbv_pkg::*;
#(
  parameter int unsigned POSITION_FRAC_BITS = PosFracBitsDef,
  parameter int unsigned ANGLE_FRAC_BITS    = AngFracBitsDef,
  parameter int unsigned TRIG_STEPS         = TrigStepsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  pbv_cmd_t    cmd_i,
  output pbv_stat_t   stat_o,
  input  logic [31:0] pos_x_i,
  input  logic [31:0] pos_y_i,
  input  logic [15:0] heading_i,
  input  logic [30:0] stamp_sec_i,
  input  logic [29:0] stamp_nsec_i,
  output logic [31:0] linear_speed_o,
  output logic [31:0] angular_speed_o,
  output logic        zero_step_o
);
  localparam int unsigned Up     = (POSITION_FRAC_BITS >= ANGLE_FRAC_BITS) ?
                                   POSITION_FRAC_BITS - ANGLE_FRAC_BITS : 0;
  localparam int unsigned Down   = (ANGLE_FRAC_BITS > POSITION_FRAC_BITS) ?
                                   ANGLE_FRAC_BITS - POSITION_FRAC_BITS : 0;
  localparam int unsigned ZUp    = 30 - ANGLE_FRAC_BITS;
  localparam int unsigned NSteps = (TRIG_STEPS < AtanEntries) ? TRIG_STEPS : AtanEntries;

  function automatic logic signed [39:0] heading_q_ext(input logic [15:0] h);
    return {{24{h[15]}}, h};
  endfunction

  logic [31:0] last_x_q, last_y_q;
  logic [15:0] last_h_q;
  logic [30:0] last_sec_q;
  logic [29:0] last_nsec_q;
  logic signed [32:0] dx_q, dy_q;
  logic signed [16:0] dh_q;
  logic [15:0] hd_q;
  logic signed [31:0] dsec_q;
  logic signed [30:0] dnsec_q;
  logic signed [62:0] dtp_q;
  logic signed [63:0] dt_q, dt_sum;
  logic        zero_q;
  logic [31:0] held_lin_q, held_ang_q;
  logic [31:0] out_lin_q, out_ang_q;
  logic        out_zero_q;
  logic        lin_neg_q;
  logic [63:0] tm_q;

  logic signed [33:0] x_q, y_q, c_v, s_v;
  logic signed [39:0] z_q, z_init;
  logic [4:0]  tcnt_q;
  logic        tbusy_q, flip_q;

  logic        div_start;
  logic [63:0] div_num, div_den, quo, mdt, v_clamp;
  logic [15:0] dh_mag;
  logic [32:0] d_mag;
  logic [33:0] c_mag, s_mag;
  logic        use_sin, busy;
  logic signed [32:0] d_sel;
  logic signed [33:0] t_sel;
  logic [33:0] t_mag;

  assign dt_sum = {dtp_q[62], dtp_q} + {{33{dnsec_q[30]}}, dnsec_q};
  assign mdt    = dt_q[63] ? 64'(-dt_q) : 64'(dt_q);
  assign dh_mag = dh_q[16] ? 16'(-dh_q) : dh_q[15:0];

  assign c_v   = flip_q ? -x_q : x_q;
  assign s_v   = flip_q ? -y_q : y_q;
  assign c_mag = c_v[33] ? 34'(-c_v) : 34'(c_v);
  assign s_mag = s_v[33] ? 34'(-s_v) : 34'(s_v);
  assign use_sin = (c_mag < s_mag);
  assign d_sel = use_sin ? dy_q : dx_q;
  assign t_sel = use_sin ? s_v : c_v;
  assign d_mag = d_sel[32] ? 33'(-d_sel) : 33'(d_sel);
  assign t_mag = t_sel[33] ? 34'(-t_sel) : 34'(t_sel);

  assign v_clamp = (quo > 64'h1_0000_0000) ? 64'h1_0000_0000 : quo;
  assign z_init  = 40'($signed(heading_q_ext(hd_q))) <<< ZUp;

  always_comb begin
    div_start = cmd_i.ang_start | cmd_i.lin_start | cmd_i.scl_start;
    div_den   = mdt;
    div_num   = (64'(dh_mag) * NsPerSec) << Up;
    if (cmd_i.lin_start) begin
      div_num = 64'(d_mag) * NsPerSec;
    end else if (cmd_i.scl_start) begin
      div_num = v_clamp << 30;
      div_den = tm_q;
    end
  end

  pbv_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .busy_o  (busy),
    .quo_o   (quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_x_q    <= '0;
      last_y_q    <= '0;
      last_h_q    <= '0;
      last_sec_q  <= '0;
      last_nsec_q <= '0;
      held_lin_q  <= '0;
      held_ang_q  <= '0;
      tbusy_q     <= 1'b0;
      tcnt_q      <= '0;
    end else begin
      if (cmd_i.load) begin
        last_x_q    <= pos_x_i;
        last_y_q    <= pos_y_i;
        last_h_q    <= heading_i;
        last_sec_q  <= stamp_sec_i;
        last_nsec_q <= stamp_nsec_i;
      end
      if (cmd_i.ang_take) begin
        held_ang_q <= sat32(dh_q[16] ^ dt_q[63], quo >> Down);
      end
      if (cmd_i.lin_take) begin
        held_lin_q <= sat32(lin_neg_q, quo);
      end
      if (cmd_i.ang_start) begin
        tbusy_q <= 1'b1;
        tcnt_q  <= '0;
      end else if (tbusy_q) begin
        tcnt_q <= tcnt_q + 1'b1;
        if (tcnt_q == 5'(NSteps - 1)) begin
          tbusy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      dx_q    <= {pos_x_i[31], pos_x_i} - {last_x_q[31], last_x_q};
      dy_q    <= {pos_y_i[31], pos_y_i} - {last_y_q[31], last_y_q};
      dh_q    <= {heading_i[15], heading_i} - {last_h_q[15], last_h_q};
      hd_q    <= heading_i;
      dsec_q  <= {1'b0, stamp_sec_i} - {1'b0, last_sec_q};
      dnsec_q <= {1'b0, stamp_nsec_i} - {1'b0, last_nsec_q};
    end
    if (cmd_i.dt_mul) begin
      dtp_q <= $signed({{31{dsec_q[31]}}, dsec_q}) * $signed(NsPerSec[62:0]);
    end
    if (cmd_i.dt_add) begin
      dt_q   <= dt_sum;
      zero_q <= (dt_sum == '0);
    end
    if (cmd_i.lin_start) begin
      lin_neg_q <= d_sel[32] ^ dt_q[63] ^ t_sel[33];
      tm_q      <= (t_mag == '0) ? 64'd1 : 64'(t_mag);
    end
    if (cmd_i.ang_start) begin
      x_q <= GainQ30;
      y_q <= '0;
      if (z_init > HalfPiQ30) begin
        z_q    <= z_init - PiQ30;
        flip_q <= 1'b1;
      end else if (z_init < -HalfPiQ30) begin
        z_q    <= z_init + PiQ30;
        flip_q <= 1'b1;
      end else begin
        z_q    <= z_init;
        flip_q <= 1'b0;
      end
    end else if (tbusy_q) begin
      if (!z_q[39]) begin
        x_q <= x_q - (y_q >>> tcnt_q);
        y_q <= y_q + (x_q >>> tcnt_q);
        z_q <= z_q - atan_q30(tcnt_q);
      end else begin
        x_q <= x_q + (y_q >>> tcnt_q);
        y_q <= y_q - (x_q >>> tcnt_q);
        z_q <= z_q + atan_q30(tcnt_q);
      end
    end
    if (cmd_i.out_load) begin
      out_lin_q  <= held_lin_q;
      out_ang_q  <= held_ang_q;
      out_zero_q <= zero_q;
    end
  end

  assign stat_o.dt_zero   = zero_q;
  assign stat_o.div_busy  = busy;
  assign stat_o.trig_busy = tbusy_q;

  assign linear_speed_o  = out_lin_q;
  assign angular_speed_o = out_ang_q;
  assign zero_step_o     = out_zero_q;
endmodule

[src/pose_to_body_velocity.sv]
// Top level of the pose-to-body-velocity estimator.
// Depends on pbv_pkg, pbv_if, pbv_ctrl and pbv_dp.
//
// Usage:
//   pose_i carries one pose word per handshake: x, y (signed Q16.16 m),
//   heading (signed Q3.13 rad), stamp seconds and nanoseconds.
//   vel_o carries one velocity word per pose: body forward speed and heading
//   rate (signed Q16.16, saturated) and zero_step.
//   When the time step is zero the divisions are skipped; otherwise each pose
//   takes three passes through the one-bit-per-cycle 64-bit divider
//   (heading rate, world x or y speed, division by cos or sin).
//   The CORDIC runs alongside the first division.
//   A new pose word is taken only after the previous one has reached the output register;
//   pose_i.ready is high only while the sequencer is idle.
//   Reset clears the stored pose, the held speeds and the output valid.
//   When the receiver stalls, the finished word holds in the output register;
//   the next pose is still taken and processed, and its result waits until
//   the output register is free.
module pose_to_body_velocity
  import pbv_pkg::*;
#(
  parameter int unsigned POSITION_FRAC_BITS = PosFracBitsDef,
  parameter int unsigned ANGLE_FRAC_BITS    = AngFracBitsDef,
  parameter int unsigned TRIG_STEPS         = TrigStepsDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  pbv_pose_if.sink   pose_i,
  pbv_vel_if.source  vel_o
);
  pbv_cmd_t  cmd;
  pbv_stat_t stat;

  pbv_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (pose_i.valid),
    .in_ready_o  (pose_i.ready),
    .out_valid_o (vel_o.valid),
    .out_ready_i (vel_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  pbv_dp #(
    .POSITION_FRAC_BITS (POSITION_FRAC_BITS),
    .ANGLE_FRAC_BITS    (ANGLE_FRAC_BITS),
    .TRIG_STEPS         (TRIG_STEPS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .pos_x_i         (pose_i.pos_x),
    .pos_y_i         (pose_i.pos_y),
    .heading_i       (pose_i.heading),
    .stamp_sec_i     (pose_i.stamp_sec),
    .stamp_nsec_i    (pose_i.stamp_nsec),
    .linear_speed_o  (vel_o.linear_speed),
    .angular_speed_o (vel_o.angular_speed),
    .zero_step_o     (vel_o.zero_step)
  );
endmodule

[src/pbv_checker.sv]
// Port-level checks for the pose-to-body-velocity block, bound to the top level.
// Depends on pose_to_body_velocity.
module pbv_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [31:0] lin_i,
  input logic [31:0] ang_i,
  input logic        zero_i
);
  logic in_acc;
  assign in_acc = in_valid_i && in_ready_i;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("velocity word dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(lin_i) && $stable(ang_i) && $stable(zero_i))
    else $error("velocity word changed while stalled");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_ready_i)
    else $error("pose taken while previous pose in flight");

  a_min_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !$rose(out_valid_i) ##1 !$rose(out_valid_i))
    else $error("velocity word appeared too early");
endmodule

bind pose_to_body_velocity pbv_checker u_pbv_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (pose_i.valid),
  .in_ready_i  (pose_i.ready),
  .out_valid_i (vel_o.valid),
  .out_ready_i (vel_o.ready),
  .lin_i       (vel_o.linear_speed),
  .ang_i       (vel_o.angular_speed),
  .zero_i      (vel_o.zero_step)
);
